[hw/rtl/vbsa_pkg.sv]
// ----------------------------------------------------------------------------
// vbsa_pkg: shared types and constants for the voice buffer slot allocator
// Field widths, result codes, register indexes and the control/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package vbsa_pkg;

	// Default sizing of the entry table.
	localparam int ENTRIES_DEF = 16;

	// Fixed field widths.
	localparam int VOICE_W  = 6;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int HANDLE_W = 24;
	localparam int GEN_W    = 16;
	localparam int COUNT_W  = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY      = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_NOTIFY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;      // latch the request and reset the scan
		logic scan_free;  // step the free/first-inactive scan
		logic take;       // mark the found entry active
		logic gen_start;  // draw the next generation candidate
		logic scan_gen;   // step the generation collision scan
		logic commit;     // write owner and generation of the new entry
		logic finish;     // load the result register
	} vbsa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;  // all entries issued and the compare stage drained
		logic found;      // an inactive entry was found
		logic hit;        // the candidate generation collides
		logic out_free;   // the result register can take a new result
	} vbsa_stat_t;

endpackage

[hw/rtl/vbsa_req_if.sv]
// ----------------------------------------------------------------------------
// vbsa_req_if: claim request channel
// Valid/ready channel carrying the voice that claims a buffer entry.
// ----------------------------------------------------------------------------
interface vbsa_req_if
	import vbsa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VOICE_W-1:0] voice;

	modport source (output valid, output voice, input ready);
	modport sink   (input valid, input voice, output ready);
endinterface

[hw/rtl/vbsa_rsp_if.sv]
// ----------------------------------------------------------------------------
// vbsa_rsp_if: claim result channel
// Valid/ready channel carrying status, slot and handle of one claim.
// ----------------------------------------------------------------------------
interface vbsa_rsp_if
	import vbsa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output status, output slot, output handle, input ready);
	modport sink   (input valid, input status, input slot, input handle, output ready);
endinterface

[hw/rtl/vbsa_ram.sv]
// ----------------------------------------------------------------------------
// vbsa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vbsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

[hw/rtl/vbsa_ctrl.sv]
// ----------------------------------------------------------------------------
// vbsa_ctrl: allocator controller
// Sequences one claim: release and search scan, entry take, generation
// draw and collision scans, commit and result hand-off.
// ----------------------------------------------------------------------------
module vbsa_ctrl
	import vbsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  vbsa_stat_t stat,
	output vbsa_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SCAN      = 3'd1;
	localparam logic [2:0] S_GEN_START = 3'd2;
	localparam logic [2:0] S_GEN_SCAN  = 3'd3;
	localparam logic [2:0] S_COMMIT    = 3'd4;
	localparam logic [2:0] S_DONE      = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_free = 1'b1;
				if (stat.scan_done) begin
					if (stat.found) begin
						cmd.take = 1'b1;
						state_d  = S_GEN_START;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_GEN_START: begin
				cmd.gen_start = 1'b1;
				state_d       = S_GEN_SCAN;
			end
			S_GEN_SCAN: begin
				cmd.scan_gen = 1'b1;
				if (stat.scan_done) begin
					state_d = stat.hit ? S_GEN_START : S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[hw/rtl/vbsa_datapath.sv]
// ----------------------------------------------------------------------------
// vbsa_datapath: allocator datapath
// Holds the configuration, entry active flags, owner and generation RAMs,
// the generation counter, the scan pipeline and the result register.
// ----------------------------------------------------------------------------
module vbsa_datapath
	import vbsa_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [VOICE_W-1:0]    req_voice,
	input  vbsa_cmd_t             cmd,
	output vbsa_stat_t            stat,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [STATUS_W-1:0]   rsp_status,
	output logic [SLOT_W-1:0]     rsp_slot,
	output logic [HANDLE_W-1:0]   rsp_handle
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Configuration registers.
	logic [COUNT_W-1:0] entry_count_q;
	logic               notify_q;

	// Entry state and counter.
	logic [ENTRIES-1:0] active_q;
	logic [GEN_W-1:0]   counter_q;

	// Per-request working registers.
	logic [VOICE_W-1:0] voice_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      idx_q;
	logic               found_q;
	logic [IW-1:0]      slot_q;
	logic [GEN_W-1:0]   gen_q;
	logic               hit_q;

	// Compare stage, aligned with the RAM read data.
	logic               valid_s1;
	logic [IW-1:0]      idx_s1;

	logic [VOICE_W-1:0] owner_rd;
	logic [GEN_W-1:0]   gen_rd;
	logic [CW-1:0]      used;
	logic               scanning;
	logic               owner_match;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [HANDLE_W-1:0] out_handle_q;

	// Owner and generation stores, read at the scan index.
	vbsa_ram #(.WIDTH(VOICE_W), .DEPTH(ENTRIES)) u_owner_ram (
		.clk     (clk),
		.wr_en   (cmd.commit),
		.wr_addr (slot_q),
		.wr_data (voice_q),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (owner_rd)
	);

	vbsa_ram #(.WIDTH(GEN_W), .DEPTH(ENTRIES)) u_gen_ram (
		.clk     (clk),
		.wr_en   (cmd.commit),
		.wr_addr (slot_q),
		.wr_data (gen_q),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (gen_rd)
	);

	// Entries in use, clamped to the table size.
	always_comb begin
		if (8'(entry_count_q) > 8'(ENTRIES)) begin
			used = CW'(ENTRIES);
		end else begin
			used = CW'(entry_count_q);
		end
	end

	assign scanning    = cmd.scan_free | cmd.scan_gen;
	assign owner_match = active_q[idx_s1] && (owner_rd == voice_q);

	assign stat.scan_done = (idx_q == n_q) && !valid_s1;
	assign stat.found     = found_q;
	assign stat.hit       = hit_q;
	assign stat.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot   = out_slot_q;
	assign rsp_handle = out_handle_q;

	// Control state: configuration, active flags, counter, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			notify_q      <= 1'b0;
			active_q      <= '0;
			counter_q     <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRY_COUNT: entry_count_q <= cfg_data;
					CFG_NOTIFY:      notify_q      <= cfg_data[0];
					default: ;
				endcase
			end
			valid_s1 <= scanning && (idx_q != n_q);
			// Release entries held by the requesting voice.
			if (cmd.scan_free && valid_s1 && owner_match) begin
				active_q[idx_s1] <= 1'b0;
			end
			if (cmd.take) begin
				active_q[slot_q] <= 1'b1;
			end
			if (cmd.gen_start) begin
				counter_q <= counter_q + GEN_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			voice_q <= req_voice;
			n_q     <= used;
			idx_q   <= '0;
			found_q <= 1'b0;
		end
		// Issue one read per cycle until the range is covered.
		if (scanning) begin
			if (idx_q != n_q) begin
				idx_q <= idx_q + CW'(1);
			end
			idx_s1 <= idx_q[IW-1:0];
		end
		// First entry that is inactive after the release.
		if (cmd.scan_free && valid_s1 && !found_q && (!active_q[idx_s1] || owner_match)) begin
			found_q <= 1'b1;
			slot_q  <= idx_s1;
		end
		if (cmd.gen_start) begin
			gen_q <= counter_q;
			idx_q <= '0;
			hit_q <= 1'b0;
		end
		// Candidate collides with a live generation.
		if (cmd.scan_gen && valid_s1 && active_q[idx_s1] && (gen_rd == gen_q)) begin
			hit_q <= 1'b1;
		end
		if (cmd.finish) begin
			if (!found_q) begin
				out_status_q <= ST_NO_FREE;
				out_slot_q   <= '0;
				out_handle_q <= '0;
			end else if (notify_q) begin
				out_status_q <= ST_GRANTED;
				out_slot_q   <= SLOT_W'(slot_q);
				out_handle_q <= {gen_q, 2'b00, voice_q};
			end else begin
				out_status_q <= ST_NO_NOTIFY;
				out_slot_q   <= SLOT_W'(slot_q);
				out_handle_q <= '0;
			end
		end
	end
endmodule

[hw/rtl/voice_buffer_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// voice_buffer_slot_allocator_unit: buffer slot allocator with generation ids
// Top level joining the allocator controller and datapath.
// ----------------------------------------------------------------------------
// One claim request is handled at a time. A claim runs the release and search
// scan over the entries in use (entry_count clamped to ENTRIES); if an entry
// is free it takes it, then runs a generation collision scan for each
// generation number tried, and commits; last it loads the result once the
// result register is free. The scans are paced by the single read port of the
// owner and generation RAMs, which are walked one entry per cycle. The next
// request is accepted as soon as the result is loaded, even while that result
// still waits on rsp. There is no clearing pass after reset.
module voice_buffer_slot_allocator_unit
	import vbsa_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vbsa_req_if.sink              req,
	vbsa_rsp_if.source            rsp
);
	vbsa_cmd_t  cmd;
	vbsa_stat_t stat;

	// Sequencer.
	vbsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, scans and result register.
	vbsa_datapath #(.ENTRIES(ENTRIES)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_voice  (req.voice),
		.cmd        (cmd),
		.stat       (stat),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_slot   (rsp.slot),
		.rsp_handle (rsp.handle)
	);
endmodule

[sim/vbsa_claim_checker.sv]
// ----------------------------------------------------------------------------
// vbsa_claim_checker: result predictor and scoreboard for the slot allocator
// Watches the configuration port and the request and result channels, keeps a shadow of
// the entry table and the generation counter, and checks every result in order.
// ----------------------------------------------------------------------------
module vbsa_claim_checker
	import vbsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vbsa_req_if                   req,
	vbsa_rsp_if                   rsp,
	output int                    fail_count,
	output int                    claims_open
);

	localparam int SLOTS     = ENTRIES_DEF;
	localparam int GEN_SHIFT = 8;

	// Shadow of the configuration registers.
	logic [COUNT_W-1:0]  entries_cfg;
	logic                notify_on;

	// Shadow of the entry table and the generation counter.
	logic [SLOTS-1:0]    slot_busy;
	logic [SLOTS-1:0]    slot_written;
	logic [VOICE_W-1:0]  slot_owner [SLOTS];
	logic [GEN_W-1:0]    slot_gen [SLOTS];
	logic [GEN_W-1:0]    gen_next;

	// Voices of accepted requests whose results have not come back yet.
	logic [VOICE_W-1:0]  claim_voices [$];

	// True when an active entry in range already holds this generation.
	// The entry named by skip is left out of the search.
	function automatic bit gen_clash(input logic [GEN_W-1:0] g, input int n, input int skip);
		for (int i = 0; i < n; i++) begin
			if (slot_busy[i] && i != skip && slot_gen[i] == g)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, what, want, got);
			fail_count++;
		end
	endtask

	// Work out the result of the oldest open request and compare it.
	task automatic settle_claim(input logic [STATUS_W-1:0] got_status,
			input logic [SLOT_W-1:0] got_slot, input logic [HANDLE_W-1:0] got_handle);
		logic [VOICE_W-1:0]  v;
		int                  n;
		int                  taken;
		int                  fresh;
		logic [GEN_W-1:0]    g_plain;
		logic [GEN_W-1:0]    g_alt;
		logic [GEN_W-1:0]    g;
		logic [STATUS_W-1:0] want_status;
		logic [HANDLE_W-1:0] want_handle;

		if (claim_voices.size() == 0) begin
			$display("%0t: unexpected result, status %0d slot %0d handle 0x%0h",
				$time, got_status, got_slot, got_handle);
			fail_count++;
			return;
		end
		v = claim_voices.pop_front();
		n = (entries_cfg > SLOTS) ? SLOTS : int'(entries_cfg);

		// Free every entry in range that this voice already holds.
		for (int i = 0; i < n; i++) begin
			if (slot_busy[i] && slot_owner[i] == v)
				slot_busy[i] = 1'b0;
		end

		// Take the lowest inactive entry.
		taken = -1;
		for (int i = 0; i < n; i++) begin
			if (taken < 0 && !slot_busy[i])
				taken = i;
		end
		if (taken < 0) begin
			check_field("status", ST_NO_FREE, got_status);
			check_field("slot", '0, got_slot);
			check_field("handle", '0, got_handle);
			return;
		end
		slot_busy[taken] = 1'b1;

		// The new entry's old generation takes part in the collision search.
		// If it was never written that number is unknown, so the counter may
		// have stepped over one more free number; the handle tells which.
		fresh = slot_written[taken] ? -1 : taken;
		g_plain = gen_next;
		while (gen_clash(g_plain, n, fresh))
			g_plain++;
		g = g_plain;
		if (fresh >= 0) begin
			g_alt = g_plain + 1'b1;
			while (gen_clash(g_alt, n, fresh))
				g_alt++;
			if (notify_on && got_handle[HANDLE_W-1:GEN_SHIFT] == g_alt)
				g = g_alt;
		end

		gen_next = g + 1'b1;
		slot_gen[taken] = g;
		slot_owner[taken] = v;
		slot_written[taken] = 1'b1;

		want_status = notify_on ? ST_GRANTED : ST_NO_NOTIFY;
		want_handle = notify_on ? {g, 2'b00, v} : '0;
		check_field("status", want_status, got_status);
		check_field("slot", taken, got_slot);
		check_field("handle", want_handle, got_handle);
	endtask

	// Sample all ports at the rising edge. A result always belongs to a request
	// accepted at an earlier edge, so it is settled before the new request queues.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_cfg = '0;
			notify_on = 1'b0;
			slot_busy = '0;
			slot_written = '0;
			gen_next = '0;
			claim_voices.delete();
			fail_count = 0;
			claims_open = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				settle_claim(rsp.status, rsp.slot, rsp.handle);
			if (req.valid && req.ready)
				claim_voices.push_back(req.voice);
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRY_COUNT: entries_cfg = cfg_data[COUNT_W-1:0];
					CFG_NOTIFY:      notify_on = cfg_data[0];
					default: ;
				endcase
			end
			claims_open = claim_voices.size();
		end
	end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the voice buffer slot allocator
// Drives claim requests and register writes, throttles the result channel,
// and reports the verdict from the failure count of the claim checker.
// ----------------------------------------------------------------------------
module tb_top
	import vbsa_pkg::*;
();

	localparam int CYCLE_LIMIT  = 5000000;
	localparam int HOLD_CYCLES  = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    claims_open;

	// Idling switches for the sender and the receiver.
	bit                    req_idle;
	bit                    rsp_idle;
	int                    hold_req;

	vbsa_req_if req_ch ();
	vbsa_rsp_if rsp_ch ();

	voice_buffer_slot_allocator_unit #(
		.ENTRIES(ENTRIES_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch.sink),
		.rsp      (rsp_ch.source)
	);

	vbsa_claim_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.claims_open(claims_open)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
	endfunction

	function automatic int sender_gap();
		return (req_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
	endfunction

	// Register write, with cfg_we dropped again before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one request after an optional gap and wait until it is taken.
	task automatic send_claim(input logic [VOICE_W-1:0] v, input int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.voice <= v;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every open request has its result.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (claims_open != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Random requests: a quarter from the whole voice range, the rest from a
	// small pool so that voices keep reclaiming the entries they own.
	task automatic run_claims(input int count, input int pool_hi);
		logic [VOICE_W-1:0] v;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				req_idle = ($urandom_range(0, 2) != 0);
				rsp_idle = ($urandom_range(0, 2) != 0);
			end
			if ($urandom_range(0, 3) == 0)
				v = VOICE_W'($urandom_range(0, 63));
			else
				v = VOICE_W'($urandom_range(0, pool_hi));
			send_claim(v, sender_gap());
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on demand.
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rsp_idle && $urandom_range(0, 99) < 25)
					stall = idle_len();
			end
		end
	end

	// Run limit.
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int ec;
		int nt;
		int cnt;
		int pool_hi;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENTRY_COUNT;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.voice = '0;
		req_idle = 1'b0;
		rsp_idle = 1'b0;
		hold_req = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// No entries in use: every claim finds no free entry.
		write_reg(CFG_ENTRY_COUNT, 0);
		write_reg(CFG_NOTIFY, 0);
		send_claim(VOICE_W'(0), 0);
		send_claim(VOICE_W'(63), 0);
		settle();

		// Fill all sixteen entries with distinct voices while notification is
		// on, so every entry gets written once; then a claim on a full table,
		// and a voice that reclaims its own entry.
		write_reg(CFG_ENTRY_COUNT, ENTRIES_DEF);
		write_reg(CFG_NOTIFY, 1);
		for (int v = 0; v < ENTRIES_DEF; v++)
			send_claim(VOICE_W'(v), 0);
		send_claim(VOICE_W'(63), 0);
		send_claim(VOICE_W'(7), 0);
		settle();

		// No notification consumer: entry allocated but reported invalid.
		write_reg(CFG_NOTIFY, 0);
		send_claim(VOICE_W'(3), 0);
		send_claim(VOICE_W'(42), 0);
		settle();

		// Entry counts above the table size are clamped.
		write_reg(CFG_ENTRY_COUNT, 31);
		write_reg(CFG_NOTIFY, 1);
		send_claim(VOICE_W'(15), 0);
		settle();
		write_reg(CFG_ENTRY_COUNT, 17);
		send_claim(VOICE_W'(0), 0);
		settle();

		// Random phases over several settings. The first one holds off the
		// receiver while the sender keeps offering requests.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					ec = ENTRIES_DEF; nt = 1; cnt = 150; pool_hi = 7;
				end
				1: begin
					ec = 0; nt = $urandom_range(0, 1); cnt = 30; pool_hi = 63;
				end
				2: begin
					ec = 31; nt = 0; cnt = 150; pool_hi = 15;
				end
				3: begin
					ec = $urandom_range(1, 15); nt = 1; cnt = 200; pool_hi = 23;
				end
				4: begin
					ec = 1; nt = 1; cnt = 100; pool_hi = 3;
				end
				5: begin
					ec = $urandom_range(0, 31); nt = $urandom_range(0, 1);
					cnt = 200; pool_hi = 31;
				end
				default: begin
					ec = ENTRIES_DEF; nt = 1; cnt = 170; pool_hi = 15;
				end
			endcase
			write_reg(CFG_ENTRY_COUNT, ec);
			write_reg(CFG_NOTIFY, nt);
			if (ph == 0) begin
				run_claims(20, pool_hi);
				hold_req = HOLD_CYCLES;
				run_claims(cnt - 20, pool_hi);
			end else begin
				run_claims(cnt, pool_hi);
			end
			settle();
		end

		rsp_idle = 1'b0;
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/vbsa_pkg.sv
hw/rtl/vbsa_req_if.sv
hw/rtl/vbsa_rsp_if.sv
hw/rtl/vbsa_ram.sv
hw/rtl/vbsa_ctrl.sv
hw/rtl/vbsa_datapath.sv
hw/rtl/voice_buffer_slot_allocator_unit.sv
sim/vbsa_claim_checker.sv
sim/tb_top.sv
